/* sv/apc_pkg.sv */
// Types and constants shared by the airspeed pitch controller modules.
package apc_pkg;

	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;
	localparam int ALU_W = 32;

	localparam int SQ_TERMS = 6;
	localparam int SQ_AIR_TERMS = 3;
	localparam int RAD_W = 30;
	localparam int ROOT_W = 15;
	localparam int REM_W = 16;
	localparam int SQRT_STEPS = 15;
	localparam int NUM_W = 28;
	localparam int DEN_W = 14;
	localparam int DIV_STEPS = 28;
	localparam int FRAC_W = 14;

	localparam logic [3:0] DESIRED_SCALE = 4'd10;
	localparam logic signed [15:0] THROTTLE_CUTOFF = 16'sd100;

	localparam logic [13:0] RST_MIN_GS = 14'd500;
	localparam logic [13:0] RST_MIN_AS = 14'd1000;
	localparam logic [13:0] RST_MAX_AS = 14'd3000;
	localparam logic [13:0] RST_CRUISE = 14'd2000;
	localparam logic [14:0] RST_LIMIT = 15'd1430;

	typedef enum logic [0:0] {
		OP_UPDATE = 1'b0,
		OP_QUERY  = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		REG_MIN_GS = 3'd0,
		REG_MIN_AS = 3'd1,
		REG_MAX_AS = 3'd2,
		REG_CRUISE = 3'd3,
		REG_LIMIT  = 3'd4,
		REG_KI     = 3'd5,
		REG_PMIN   = 3'd6,
		REG_PMAX   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [13:0]        min_gs;
		logic [13:0]        min_as;
		logic [13:0]        max_as;
		logic [13:0]        cruise;
		logic [14:0]        limit;
		logic signed [15:0] ki;
		logic signed [15:0] pmin;
		logic signed [15:0] pmax;
	} cfg_t;

	typedef struct packed {
		logic              psel;
		logic              penable;
		logic              pwrite;
		logic [CFG_AW-1:0] paddr;
		logic [CFG_DW-1:0] pwdata;
	} apb_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] sum;
		logic             carry;
	} alu_rsp_t;

	typedef enum logic [15:0] {
		ST_IDLE      = 16'b0000_0000_0000_0001,
		ST_SQ        = 16'b0000_0000_0000_0010,
		ST_SQRT      = 16'b0000_0000_0000_0100,
		ST_TGT_RAISE = 16'b0000_0000_0000_1000,
		ST_TGT_CLAMP = 16'b0000_0000_0001_0000,
		ST_ERR       = 16'b0000_0000_0010_0000,
		ST_IMUL      = 16'b0000_0000_0100_0000,
		ST_IACC      = 16'b0000_0000_1000_0000,
		ST_ICLAMP    = 16'b0000_0001_0000_0000,
		ST_DSETUP    = 16'b0000_0010_0000_0000,
		ST_DIV       = 16'b0000_0100_0000_0000,
		ST_DSAT      = 16'b0000_1000_0000_0000,
		ST_PMUL      = 16'b0001_0000_0000_0000,
		ST_PADJ      = 16'b0010_0000_0000_0000,
		ST_PRATE     = 16'b0100_0000_0000_0000,
		ST_FIN       = 16'b1000_0000_0000_0000
	} state_t;

endpackage

/* sv/apc_if.sv */
// Valid/ready channel interfaces for controller requests and results.
interface apc_in_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic signed [13:0] vel_x;
	logic signed [13:0] vel_y;
	logic signed [13:0] vel_z;
	logic signed [12:0] wind_x;
	logic signed [12:0] wind_y;
	logic signed [12:0] wind_z;
	logic [9:0]         desired_speed;
	logic signed [15:0] throttle;

	modport source (
		output valid, opcode, vel_x, vel_y, vel_z, wind_x, wind_y, wind_z,
		output desired_speed, throttle,
		input  ready
	);
	modport sink (
		input  valid, opcode, vel_x, vel_y, vel_z, wind_x, wind_y, wind_z,
		input  desired_speed, throttle,
		output ready
	);
endinterface

interface apc_out_if;
	logic               valid;
	logic               ready;
	logic [14:0]        airspeed_out;
	logic [13:0]        groundspeed_out;
	logic [13:0]        target_out;
	logic signed [15:0] error_out;
	logic signed [15:0] integral_out;
	logic signed [15:0] pitch_adjust_out;

	modport source (
		output valid, airspeed_out, groundspeed_out, target_out, error_out,
		output integral_out, pitch_adjust_out,
		input  ready
	);
	modport sink (
		input  valid, airspeed_out, groundspeed_out, target_out, error_out,
		input  integral_out, pitch_adjust_out,
		output ready
	);
endinterface

/* sv/apc_alu.sv */
// Shared adder and subtractor used by every iterative step of the controller.
module apc_alu (
	input  apc_pkg::alu_req_t req,
	output apc_pkg::alu_rsp_t rsp
);
	localparam int SUM_W = apc_pkg::ALU_W + 1;

	logic [apc_pkg::ALU_W-1:0] operand_b;
	logic [SUM_W-1:0]          total;

	always_comb begin
		operand_b = req.sub ? ~req.b : req.b;
		total = {1'b0, req.a} + {1'b0, operand_b} + SUM_W'(req.sub);
		rsp.sum = total[apc_pkg::ALU_W-1:0];
		rsp.carry = total[SUM_W-1];
	end
endmodule

/* sv/apc_cfg.sv */
// APB configuration register file of the airspeed pitch controller.
module apc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  apc_pkg::apb_req_t            apb,
	output logic [apc_pkg::CFG_DW-1:0]   prdata,
	output apc_pkg::cfg_t                cfg
);
	apc_pkg::cfg_t     cfg_q;
	apc_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx = apc_pkg::reg_idx_t'(apb.paddr[apc_pkg::CFG_AW-1:2]);
	assign wr_en = apb.psel && apb.penable && apb.pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_gs <= apc_pkg::RST_MIN_GS;
			cfg_q.min_as <= apc_pkg::RST_MIN_AS;
			cfg_q.max_as <= apc_pkg::RST_MAX_AS;
			cfg_q.cruise <= apc_pkg::RST_CRUISE;
			cfg_q.limit <= apc_pkg::RST_LIMIT;
			cfg_q.ki <= '0;
			cfg_q.pmin <= '0;
			cfg_q.pmax <= '0;
		end else if (wr_en) begin
			unique case (idx)
				apc_pkg::REG_MIN_GS: cfg_q.min_gs <= apb.pwdata[13:0];
				apc_pkg::REG_MIN_AS: cfg_q.min_as <= apb.pwdata[13:0];
				apc_pkg::REG_MAX_AS: cfg_q.max_as <= apb.pwdata[13:0];
				apc_pkg::REG_CRUISE: cfg_q.cruise <= apb.pwdata[13:0];
				apc_pkg::REG_LIMIT:  cfg_q.limit <= apb.pwdata[14:0];
				apc_pkg::REG_KI:     cfg_q.ki <= apb.pwdata[15:0];
				apc_pkg::REG_PMIN:   cfg_q.pmin <= apb.pwdata[15:0];
				apc_pkg::REG_PMAX:   cfg_q.pmax <= apb.pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			apc_pkg::REG_MIN_GS: prdata = apc_pkg::CFG_DW'(cfg_q.min_gs);
			apc_pkg::REG_MIN_AS: prdata = apc_pkg::CFG_DW'(cfg_q.min_as);
			apc_pkg::REG_MAX_AS: prdata = apc_pkg::CFG_DW'(cfg_q.max_as);
			apc_pkg::REG_CRUISE: prdata = apc_pkg::CFG_DW'(cfg_q.cruise);
			apc_pkg::REG_LIMIT:  prdata = apc_pkg::CFG_DW'(cfg_q.limit);
			apc_pkg::REG_KI:     prdata = apc_pkg::CFG_DW'($unsigned(cfg_q.ki));
			apc_pkg::REG_PMIN:   prdata = apc_pkg::CFG_DW'($unsigned(cfg_q.pmin));
			apc_pkg::REG_PMAX:   prdata = apc_pkg::CFG_DW'($unsigned(cfg_q.pmax));
		endcase
	end
endmodule

/* sv/apc_core.sv */
// Sequencer and datapath registers of the airspeed pitch controller.
module apc_core #(
	parameter int PITCH_RATE_STEP = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	apc_in_if.sink            item,
	apc_out_if.source         result,
	input  apc_pkg::cfg_t     cfg,
	output apc_pkg::alu_req_t alu_req,
	input  apc_pkg::alu_rsp_t alu_rsp
);
	localparam int CNT_W = $clog2(apc_pkg::DIV_STEPS + 1);
	localparam logic signed [17:0] STEP = 18'(PITCH_RATE_STEP);
	localparam int ALU_W = apc_pkg::ALU_W;

	apc_pkg::state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             sqrt_sel_q;
	logic             out_valid_q;

	logic [14:0]        speed_air_q;
	logic [13:0]        speed_gs_q;
	logic [13:0]        target_q;
	logic signed [15:0] fe_q;
	logic [31:0]        acc_q;
	logic signed [15:0] last_q;

	logic signed [14:0] sq_q [apc_pkg::SQ_TERMS];
	logic [9:0]         desired_q;
	logic signed [15:0] throttle_q;
	logic [apc_pkg::RAD_W-1:0] a2_q;
	logic [apc_pkg::RAD_W-1:0] g2_q;
	logic signed [31:0] prod_q;
	logic [apc_pkg::RAD_W-1:0]  rad_q;
	logic [apc_pkg::REM_W-1:0]  rem_q;
	logic [apc_pkg::ROOT_W-1:0] root_q;
	logic [14:0]        tgt_raw_q;
	logic [apc_pkg::NUM_W-1:0] num_q;
	logic [apc_pkg::DEN_W-1:0] den_q;
	logic [apc_pkg::DEN_W-1:0] drem_q;
	logic [apc_pkg::NUM_W-1:0] quo_q;
	logic               neg_q;
	logic signed [15:0] pitch_q;
	logic signed [15:0] qsat_q;
	logic signed [15:0] adj_q;

	logic [14:0]        air_out_q;
	logic [13:0]        gs_out_q;
	logic [13:0]        tgt_out_q;
	logic signed [15:0] err_out_q;
	logic signed [15:0] int_out_q;
	logic signed [15:0] pitch_out_q;

	logic signed [15:0] mul_a;
	logic signed [15:0] mul_b;
	logic signed [31:0] prod_d;
	logic [17:0]        rem_pre;
	logic [16:0]        trial;
	logic [apc_pkg::ROOT_W-1:0] root_nxt;
	logic [apc_pkg::REM_W-1:0]  rem_nxt;
	logic [apc_pkg::DEN_W:0]    drem_pre;
	logic [apc_pkg::DEN_W-1:0]  drem_nxt;
	logic [apc_pkg::NUM_W-1:0]  quo_nxt;
	logic [14:0]        d10;
	logic [14:0]        tgt_raise;
	logic [13:0]        tgt_hi;
	logic [13:0]        tgt_clamp;
	logic signed [16:0] err_diff;
	logic signed [15:0] fe_nxt;
	logic signed [15:0] acc_hi;
	logic signed [15:0] lim;
	logic signed [15:0] hi_clamp;
	logic signed [14:0] delta;
	logic signed [14:0] range_raw;
	logic signed [14:0] range_fix;
	logic signed [15:0] pitch_sel;
	logic [13:0]        dabs;
	logic               range_neg;
	logic [apc_pkg::DEN_W-1:0] den_nxt;
	logic signed [15:0] qsat_nxt;
	logic signed [15:0] adj_raw;
	logic               throttle_cut;
	logic signed [17:0] rate_diff;
	logic signed [15:0] last_nxt;
	logic               accept;
	logic               fin_go;

	assign accept = item.valid && item.ready;
	assign item.ready = (state_q == apc_pkg::ST_IDLE);
	assign fin_go = (state_q == apc_pkg::ST_FIN) && (!out_valid_q || result.ready);

	assign result.valid = out_valid_q;
	assign result.airspeed_out = air_out_q;
	assign result.groundspeed_out = gs_out_q;
	assign result.target_out = tgt_out_q;
	assign result.error_out = err_out_q;
	assign result.integral_out = int_out_q;
	assign result.pitch_adjust_out = pitch_out_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			apc_pkg::ST_SQ: begin
				mul_a = 16'(sq_q[0]);
				mul_b = 16'(sq_q[0]);
			end
			apc_pkg::ST_IMUL: begin
				mul_a = cfg.ki;
				mul_b = fe_q;
			end
			apc_pkg::ST_PMUL: begin
				mul_a = qsat_q;
				mul_b = pitch_q;
			end
			default: begin
			end
		endcase
		prod_d = mul_a * mul_b;
	end

	assign rem_pre = {rem_q, rad_q[apc_pkg::RAD_W-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign root_nxt = {root_q[apc_pkg::ROOT_W-2:0], alu_rsp.carry};
	assign rem_nxt = alu_rsp.carry ? alu_rsp.sum[apc_pkg::REM_W-1:0] : rem_pre[apc_pkg::REM_W-1:0];
	assign drem_pre = {drem_q, num_q[apc_pkg::NUM_W-1]};
	assign drem_nxt = alu_rsp.carry ? alu_rsp.sum[apc_pkg::DEN_W-1:0]
		: drem_pre[apc_pkg::DEN_W-1:0];
	assign quo_nxt = {quo_q[apc_pkg::NUM_W-2:0], alu_rsp.carry};

	always_comb begin
		alu_req = '0;
		unique case (state_q)
			apc_pkg::ST_SQ: begin
				alu_req.a = (cnt_q <= CNT_W'(apc_pkg::SQ_AIR_TERMS)) ? ALU_W'(a2_q) : ALU_W'(g2_q);
				alu_req.b = prod_q;
			end
			apc_pkg::ST_SQRT: begin
				alu_req.a = ALU_W'(rem_pre);
				alu_req.b = ALU_W'(trial);
				alu_req.sub = 1'b1;
			end
			apc_pkg::ST_DIV: begin
				alu_req.a = ALU_W'(drem_pre);
				alu_req.b = ALU_W'(den_q);
				alu_req.sub = 1'b1;
			end
			apc_pkg::ST_IACC: begin
				alu_req.a = acc_q;
				alu_req.b = {prod_q[29:0], 2'b00};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		d10 = 15'(desired_q) * 15'(apc_pkg::DESIRED_SCALE);
		tgt_raise = (speed_gs_q < cfg.min_gs)
			? d10 + 15'(cfg.min_gs) - 15'(speed_gs_q) : d10;
		tgt_hi = (tgt_raw_q > 15'(cfg.max_as)) ? cfg.max_as : tgt_raw_q[13:0];
		tgt_clamp = (tgt_hi < cfg.min_as) ? cfg.min_as : tgt_hi;
		err_diff = $signed({3'b000, target_q}) - $signed({2'b00, speed_air_q});
		fe_nxt = (fe_q >>> 1) + 16'(err_diff >>> 1);

		acc_hi = $signed(acc_q[31:16]);
		lim = $signed({1'b0, cfg.limit});
		if (acc_hi > lim) begin
			hi_clamp = lim;
		end else if (acc_hi < -lim) begin
			hi_clamp = -lim;
		end else begin
			hi_clamp = acc_hi;
		end
	end

	always_comb begin
		delta = $signed({1'b0, target_q}) - $signed({1'b0, cfg.cruise});
		if (delta > 15'sd0) begin
			range_raw = $signed({1'b0, cfg.max_as}) - $signed({1'b0, cfg.cruise});
			pitch_sel = cfg.pmax;
			dabs = delta[13:0];
		end else if (delta < 15'sd0) begin
			range_raw = $signed({1'b0, cfg.cruise}) - $signed({1'b0, cfg.min_as});
			pitch_sel = cfg.pmin;
			dabs = 14'(-delta);
		end else begin
			range_raw = 15'sd1;
			pitch_sel = '0;
			dabs = '0;
		end
		range_fix = (range_raw == 15'sd0) ? 15'sd1 : range_raw;
		range_neg = range_fix[14];
		den_nxt = range_neg ? 14'(-range_fix) : range_fix[13:0];

		if (!neg_q) begin
			qsat_nxt = (quo_q > apc_pkg::NUM_W'(32767)) ? 16'sh7FFF : $signed(quo_q[15:0]);
		end else begin
			qsat_nxt = (quo_q > apc_pkg::NUM_W'(32768)) ? 16'sh8000
				: $signed(16'(16'd0 - quo_q[15:0]));
		end

		adj_raw = $signed(prod_q[29:14]) - $signed(acc_q[31:16]);
		throttle_cut = (throttle_q >= apc_pkg::THROTTLE_CUTOFF);

		rate_diff = 18'(adj_q) - 18'(last_q);
		if (rate_diff > STEP) begin
			last_nxt = 16'(18'(last_q) + STEP);
		end else if (rate_diff < -STEP) begin
			last_nxt = 16'(18'(last_q) - STEP);
		end else begin
			last_nxt = adj_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apc_pkg::ST_IDLE;
			cnt_q <= '0;
			sqrt_sel_q <= 1'b0;
			out_valid_q <= 1'b0;
			speed_air_q <= '0;
			speed_gs_q <= '0;
			target_q <= '0;
			fe_q <= '0;
			acc_q <= '0;
			last_q <= '0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				apc_pkg::ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						state_q <= (apc_pkg::opcode_t'(item.opcode) == apc_pkg::OP_UPDATE)
							? apc_pkg::ST_SQ : apc_pkg::ST_DSETUP;
					end
				end
				apc_pkg::ST_SQ: begin
					if (cnt_q == CNT_W'(apc_pkg::SQ_TERMS)) begin
						cnt_q <= '0;
						sqrt_sel_q <= 1'b0;
						state_q <= apc_pkg::ST_SQRT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				apc_pkg::ST_SQRT: begin
					if (cnt_q == CNT_W'(apc_pkg::SQRT_STEPS - 1)) begin
						cnt_q <= '0;
						if (!sqrt_sel_q) begin
							speed_air_q <= root_nxt;
							sqrt_sel_q <= 1'b1;
						end else begin
							speed_gs_q <= root_nxt[13:0];
							state_q <= apc_pkg::ST_TGT_RAISE;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				apc_pkg::ST_TGT_RAISE: state_q <= apc_pkg::ST_TGT_CLAMP;
				apc_pkg::ST_TGT_CLAMP: begin
					target_q <= tgt_clamp;
					state_q <= apc_pkg::ST_ERR;
				end
				apc_pkg::ST_ERR: begin
					fe_q <= fe_nxt;
					state_q <= apc_pkg::ST_IMUL;
				end
				apc_pkg::ST_IMUL: state_q <= apc_pkg::ST_IACC;
				apc_pkg::ST_IACC: begin
					acc_q <= alu_rsp.sum;
					state_q <= apc_pkg::ST_ICLAMP;
				end
				apc_pkg::ST_ICLAMP: begin
					acc_q[31:16] <= hi_clamp;
					state_q <= apc_pkg::ST_FIN;
				end
				apc_pkg::ST_DSETUP: begin
					cnt_q <= '0;
					state_q <= apc_pkg::ST_DIV;
				end
				apc_pkg::ST_DIV: begin
					if (cnt_q == CNT_W'(apc_pkg::DIV_STEPS - 1)) begin
						cnt_q <= '0;
						state_q <= apc_pkg::ST_DSAT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				apc_pkg::ST_DSAT: state_q <= apc_pkg::ST_PMUL;
				apc_pkg::ST_PMUL: state_q <= apc_pkg::ST_PADJ;
				apc_pkg::ST_PADJ: begin
					if (throttle_cut) begin
						acc_q <= '0;
					end
					state_q <= apc_pkg::ST_PRATE;
				end
				apc_pkg::ST_PRATE: begin
					last_q <= last_nxt;
					state_q <= apc_pkg::ST_FIN;
				end
				apc_pkg::ST_FIN: begin
					if (fin_go) begin
						state_q <= apc_pkg::ST_IDLE;
					end
				end
				default: state_q <= apc_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			apc_pkg::ST_IDLE: begin
				if (accept) begin
					sq_q[0] <= 15'(item.vel_x) - 15'(item.wind_x);
					sq_q[1] <= 15'(item.vel_y) - 15'(item.wind_y);
					sq_q[2] <= 15'(item.vel_z) - 15'(item.wind_z);
					sq_q[3] <= 15'(item.vel_x);
					sq_q[4] <= 15'(item.vel_y);
					sq_q[5] <= 15'(item.vel_z);
					desired_q <= item.desired_speed;
					throttle_q <= item.throttle;
					a2_q <= '0;
					g2_q <= '0;
				end
			end
			apc_pkg::ST_SQ: begin
				prod_q <= prod_d;
				for (int i = 0; i < apc_pkg::SQ_TERMS - 1; i++) begin
					sq_q[i] <= sq_q[i + 1];
				end
				if (cnt_q != '0 && cnt_q <= CNT_W'(apc_pkg::SQ_AIR_TERMS)) begin
					a2_q <= alu_rsp.sum[apc_pkg::RAD_W-1:0];
				end else if (cnt_q > CNT_W'(apc_pkg::SQ_AIR_TERMS)) begin
					g2_q <= alu_rsp.sum[apc_pkg::RAD_W-1:0];
				end
				if (cnt_q == CNT_W'(apc_pkg::SQ_TERMS)) begin
					rad_q <= a2_q;
					rem_q <= '0;
					root_q <= '0;
				end
			end
			apc_pkg::ST_SQRT: begin
				if (cnt_q == CNT_W'(apc_pkg::SQRT_STEPS - 1) && !sqrt_sel_q) begin
					rad_q <= g2_q;
					rem_q <= '0;
					root_q <= '0;
				end else begin
					rad_q <= {rad_q[apc_pkg::RAD_W-3:0], 2'b00};
					rem_q <= rem_nxt;
					root_q <= root_nxt;
				end
			end
			apc_pkg::ST_TGT_RAISE: tgt_raw_q <= tgt_raise;
			apc_pkg::ST_IMUL: prod_q <= prod_d;
			apc_pkg::ST_DSETUP: begin
				num_q <= {dabs, apc_pkg::FRAC_W'(0)};
				den_q <= den_nxt;
				neg_q <= range_neg;
				pitch_q <= pitch_sel;
				drem_q <= '0;
				quo_q <= '0;
			end
			apc_pkg::ST_DIV: begin
				num_q <= {num_q[apc_pkg::NUM_W-2:0], 1'b0};
				drem_q <= drem_nxt;
				quo_q <= quo_nxt;
			end
			apc_pkg::ST_DSAT: qsat_q <= qsat_nxt;
			apc_pkg::ST_PMUL: prod_q <= prod_d;
			apc_pkg::ST_PADJ: adj_q <= throttle_cut ? 16'sd0 : adj_raw;
			apc_pkg::ST_FIN: begin
				if (fin_go) begin
					air_out_q <= speed_air_q;
					gs_out_q <= speed_gs_q;
					tgt_out_q <= target_q;
					err_out_q <= fe_q;
					int_out_q <= $signed(acc_q[31:16]);
					pitch_out_q <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == apc_pkg::ST_IDLE && !accept) |=> (state_q == apc_pkg::ST_IDLE))
		else $error("Sequencer left idle without an input transaction.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == apc_pkg::ST_FIN))
		else $error("Result became valid outside the finishing step.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == apc_pkg::ST_FIN && result.valid && !result.ready)
		|=> (state_q == apc_pkg::ST_FIN))
		else $error("Finished item overwrote a result that was not yet taken.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == apc_pkg::ST_SQRT || state_q == apc_pkg::ST_DIV)
		|-> (cnt_q < CNT_W'(apc_pkg::DIV_STEPS)))
		else $error("Step counter ran past the iteration length.");
endmodule

/* sv/airspeed_pitch_controller.sv */
// Top level of the airspeed pitch controller.
// One transaction is taken at a time and the input is not ready until its result has been
// placed in the output register. A control update computes six squares through the shared
// multiplier, then two 15-step bit-serial square roots and the integral update through
// the shared 32-bit adder. A glide pitch query runs a 28-step restoring divide on the
// same adder. A result waiting in the output register holds back only the completion
// of the next item.
module airspeed_pitch_controller #(
	parameter int PITCH_RATE_STEP = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	apc_in_if.sink                     item,
	apc_out_if.source                  result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [apc_pkg::CFG_AW-1:0] paddr,
	input  logic [apc_pkg::CFG_DW-1:0] pwdata,
	output logic [apc_pkg::CFG_DW-1:0] prdata,
	output logic                       pready
);
	apc_pkg::apb_req_t apb;
	apc_pkg::cfg_t     cfg;
	apc_pkg::alu_req_t alu_req;
	apc_pkg::alu_rsp_t alu_rsp;

	assign apb.psel = psel;
	assign apb.penable = penable;
	assign apb.pwrite = pwrite;
	assign apb.paddr = paddr;
	assign apb.pwdata = pwdata;
	assign pready = 1'b1;

	apc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.apb    (apb),
		.prdata (prdata),
		.cfg    (cfg)
	);

	apc_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	apc_core #(
		.PITCH_RATE_STEP (PITCH_RATE_STEP)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.result  (result),
		.cfg     (cfg),
		.alu_req (alu_req),
		.alu_rsp (alu_rsp)
	);
endmodule
